FILE: sv/dpkip_pkg.sv
// Package for the DER private key integer parser.
// Holds tag values, parser phase and role codes, result kinds, error codes and the result type.
// Depends on nothing; all files but the two channel interfaces import it.
package dpkip_pkg;

	// DER tags and the long-form length marker.
	localparam logic [7:0] TAG_SEQ       = 8'h30;
	localparam logic [7:0] TAG_INT       = 8'h02;
	localparam logic [7:0] LONG_FORM_BIT = 8'h80;

	// Integer counts per key kind.
	localparam logic       KEY_RSA       = 1'b0;
	localparam logic [4:0] RSA_INT_COUNT = 5'd8;
	localparam logic [4:0] DSA_INT_COUNT = 5'd5;

	// Parser phases.
	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_TAG       = 3'd1;
	localparam logic [2:0] PH_LEN_FIRST = 3'd2;
	localparam logic [2:0] PH_LEN_MORE  = 3'd3;
	localparam logic [2:0] PH_VERSION   = 3'd4;
	localparam logic [2:0] PH_CONTENT   = 3'd5;

	// Which header is being parsed.
	localparam logic [1:0] ROLE_SEQ = 2'd0;
	localparam logic [1:0] ROLE_VER = 2'd1;
	localparam logic [1:0] ROLE_INT = 2'd2;

	// Result kinds.
	localparam logic [1:0] KIND_CONTENT = 2'd0;
	localparam logic [1:0] KIND_DONE    = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	// Error codes.
	localparam logic [2:0] ERR_NONE        = 3'd0;
	localparam logic [2:0] ERR_NO_SEQUENCE = 3'd1;
	localparam logic [2:0] ERR_VER_HEADER  = 3'd2;
	localparam logic [2:0] ERR_BAD_VERSION = 3'd3;
	localparam logic [2:0] ERR_NOT_INT     = 3'd4;
	localparam logic [2:0] ERR_LEN_FORM    = 3'd5;

	// Configuration register indexes.
	localparam logic CFG_KEY_KIND = 1'b0;
	localparam logic CFG_VERSION  = 1'b1;

	// One result item.
	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] field_index;
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       last_in_field;
		logic [2:0] error_code;
	} dpkip_result_t;

	// What one parsed byte produces.
	typedef struct packed {
		logic          emit;
		dpkip_result_t res;
	} dpkip_step_t;

endpackage

FILE: sv/dpkip_in_if.sv
// Byte input channel of the DER private key integer parser.
// Carries valid, ready and one blob byte with its start mark; no package dependency.
interface dpkip_in_if;
	logic       valid;
	logic       ready;
	logic       first_byte;
	logic [7:0] in_byte;

	modport source (output valid, output first_byte, output in_byte, input ready);
	modport sink (input valid, input first_byte, input in_byte, output ready);
endinterface

FILE: sv/dpkip_out_if.sv
// Result output channel of the DER private key integer parser.
// Carries valid, ready and the fields of one result; no package dependency.
interface dpkip_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [2:0] field_index;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       last_in_field;
	logic [2:0] error_code;

	modport source (output valid, output kind, output field_index, output out_byte,
		output byte_valid, output last_in_field, output error_code, input ready);
	modport sink (input valid, input kind, input field_index, input out_byte,
		input byte_valid, input last_in_field, input error_code, output ready);
endinterface

FILE: sv/dpkip_core.sv
// Parser state machine: consumes one DER byte per step and decides the result for it.
// Depends on dpkip_pkg for codes and the step result type.
module dpkip_core
	import dpkip_pkg::*;
#(
	parameter int LENGTH_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic        first_byte,
	input  logic [7:0]  in_byte,
	input  logic        key_kind,
	input  logic [7:0]  version_value,
	output dpkip_step_t outcome
);

	logic [2:0]              phase_q, phase_n, ph;
	logic [1:0]              role_q, role_n, role;
	logic [2:0]              left_q, left_n, left;
	logic [LENGTH_WIDTH-1:0] len_q, len_n, len;
	logic [3:0]              fc_q, fc_n, fc;
	logic [LENGTH_WIDTH+7:0] shifted;
	logic                    hdr_end, fin, fail;
	logic [7:0]              fin_byte;
	logic                    fin_valid;
	logic [2:0]              fail_code;
	logic [4:0]              need;
	logic [2:0]              nb;

	// A first byte restarts the blob before the byte is parsed.
	always_comb begin
		ph   = first_byte ? PH_TAG : phase_q;
		role = first_byte ? ROLE_SEQ : role_q;
		left = first_byte ? 3'd0 : left_q;
		len  = first_byte ? '0 : len_q;
		fc   = first_byte ? 4'd0 : fc_q;
	end

	assign shifted = {len, in_byte};
	assign need    = (key_kind == KEY_RSA) ? RSA_INT_COUNT : DSA_INT_COUNT;
	assign nb      = in_byte[2:0];

	// Next state and result for the current byte.
	always_comb begin
		phase_n   = ph;
		role_n    = role;
		left_n    = left;
		len_n     = len;
		fc_n      = fc;
		hdr_end   = 1'b0;
		fin       = 1'b0;
		fin_byte  = 8'd0;
		fin_valid = 1'b0;
		fail      = 1'b0;
		fail_code = ERR_NONE;
		outcome   = '0;

		unique case (ph)
			PH_TAG: begin
				phase_n = PH_LEN_FIRST;
				if (role == ROLE_SEQ && in_byte != TAG_SEQ) begin
					fail = 1'b1;
					fail_code = ERR_NO_SEQUENCE;
				end else if (role == ROLE_VER && in_byte != TAG_INT) begin
					fail = 1'b1;
					fail_code = ERR_VER_HEADER;
				end else if (role == ROLE_INT && in_byte != TAG_INT) begin
					fail = 1'b1;
					fail_code = ERR_NOT_INT;
				end
			end
			PH_LEN_FIRST: begin
				if ((in_byte & LONG_FORM_BIT) != 8'd0) begin
					// Long form: only one, two or four length bytes are legal.
					if (in_byte[6:3] != 4'd0 || (nb != 3'd1 && nb != 3'd2 && nb != 3'd4)) begin
						fail = 1'b1;
						fail_code = ERR_LEN_FORM;
					end else begin
						left_n  = nb;
						len_n   = '0;
						phase_n = PH_LEN_MORE;
					end
				end else begin
					len_n   = LENGTH_WIDTH'(in_byte);
					hdr_end = 1'b1;
				end
			end
			PH_LEN_MORE: begin
				len_n  = shifted[LENGTH_WIDTH-1:0];
				left_n = left - 3'd1;
				if (left_n == 3'd0) begin
					hdr_end = 1'b1;
				end
			end
			PH_VERSION: begin
				if (in_byte != version_value) begin
					fail = 1'b1;
					fail_code = ERR_BAD_VERSION;
				end else begin
					role_n  = ROLE_INT;
					fc_n    = 4'd0;
					phase_n = PH_TAG;
				end
			end
			PH_CONTENT: begin
				len_n = len - LENGTH_WIDTH'(1);
				if (len_n == '0) begin
					fin       = 1'b1;
					fin_byte  = in_byte;
					fin_valid = 1'b1;
				end else begin
					outcome.emit              = 1'b1;
					outcome.res.kind          = KIND_CONTENT;
					outcome.res.field_index   = fc[2:0];
					outcome.res.out_byte      = in_byte;
					outcome.res.byte_valid    = 1'b1;
					outcome.res.last_in_field = 1'b0;
					outcome.res.error_code    = ERR_NONE;
				end
			end
			default: begin
				phase_n = PH_IDLE;
			end
		endcase

		// A complete header: advance depending on which header it was.
		if (hdr_end) begin
			unique case (role)
				ROLE_SEQ: begin
					role_n  = ROLE_VER;
					phase_n = PH_TAG;
				end
				ROLE_VER: begin
					if (len_n != LENGTH_WIDTH'(1)) begin
						fail = 1'b1;
						fail_code = ERR_VER_HEADER;
					end else begin
						phase_n = PH_VERSION;
					end
				end
				default: begin
					if (len_n == '0) begin
						fin = 1'b1;
					end else begin
						phase_n = PH_CONTENT;
					end
				end
			endcase
		end

		// Last result of an integer; the final integer reports done instead.
		if (fin) begin
			outcome.emit              = 1'b1;
			outcome.res.field_index   = fc[2:0];
			outcome.res.out_byte      = fin_byte;
			outcome.res.byte_valid    = fin_valid;
			outcome.res.last_in_field = 1'b1;
			outcome.res.error_code    = ERR_NONE;
			if ({1'b0, fc} + 5'd1 >= need) begin
				outcome.res.kind = KIND_DONE;
				phase_n = PH_IDLE;
			end else begin
				outcome.res.kind = KIND_CONTENT;
				fc_n    = fc + 4'd1;
				phase_n = PH_TAG;
			end
		end

		// Any error ends the blob.
		if (fail) begin
			outcome.emit              = 1'b1;
			outcome.res.kind          = KIND_ERROR;
			outcome.res.field_index   = fc[2:0];
			outcome.res.out_byte      = 8'd0;
			outcome.res.byte_valid    = 1'b0;
			outcome.res.last_in_field = 1'b0;
			outcome.res.error_code    = fail_code;
			phase_n = PH_IDLE;
		end
	end

	// Parser state registers advance only on an accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			role_q  <= ROLE_SEQ;
			left_q  <= 3'd0;
			len_q   <= '0;
			fc_q    <= 4'd0;
		end else if (step) begin
			phase_q <= phase_n;
			role_q  <= role_n;
			left_q  <= left_n;
			len_q   <= len_n;
			fc_q    <= fc_n;
		end
	end

endmodule

FILE: sv/der_private_key_integer_parser_top.sv
// A result is registered and appears on the output channel in the cycle after the byte that causes it.
// Throughput: one byte per cycle; the output register takes a new result in the cycle
// its old one is taken, so input ready is low only while an unaccepted result is held.
// Reset (arst_n, asynchronous): parser idle, configuration registers zero, no result held.
// Depends on dpkip_pkg, dpkip_in_if, dpkip_out_if and dpkip_core.
module der_private_key_integer_parser_top
	import dpkip_pkg::*;
#(
	parameter int LENGTH_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	dpkip_in_if.sink    blob,
	dpkip_out_if.source fields,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	logic          key_kind_q;
	logic [7:0]    version_q;
	logic          out_valid_q;
	dpkip_result_t out_res_q;
	dpkip_step_t   outcome;
	logic          accept;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_kind_q <= 1'b0;
			version_q  <= 8'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY_KIND: key_kind_q <= cfg_data[0];
				CFG_VERSION:  version_q  <= cfg_data;
				default:      key_kind_q <= key_kind_q;
			endcase
		end
	end

	// A byte is taken whenever the output register is free or being emptied.
	assign blob.ready = !out_valid_q || fields.ready;
	assign accept     = blob.valid && blob.ready;

	dpkip_core #(
		.LENGTH_WIDTH(LENGTH_WIDTH)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (accept),
		.first_byte   (blob.first_byte),
		.in_byte      (blob.in_byte),
		.key_kind     (key_kind_q),
		.version_value(version_q),
		.outcome      (outcome)
	);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= outcome.emit;
		end else if (fields.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (accept && outcome.emit) begin
			out_res_q <= outcome.res;
		end
	end

	assign fields.valid         = out_valid_q;
	assign fields.kind          = out_res_q.kind;
	assign fields.field_index   = out_res_q.field_index;
	assign fields.out_byte      = out_res_q.out_byte;
	assign fields.byte_valid    = out_res_q.byte_valid;
	assign fields.last_in_field = out_res_q.last_in_field;
	assign fields.error_code    = out_res_q.error_code;

endmodule

FILE: sv/dpkip_checker.sv
// Port-level checks for the DER private key integer parser, bound to the top level.
// Depends on dpkip_pkg for the result kind and error codes.
module dpkip_checker
	import dpkip_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] kind,
	input logic [2:0] field_index,
	input logic [7:0] out_byte,
	input logic       byte_valid,
	input logic       last_in_field,
	input logic [2:0] error_code
);

	// A held result does not change while the sink stalls.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(field_index)
			&& $stable(out_byte) && $stable(byte_valid) && $stable(last_in_field)
			&& $stable(error_code))
		else $error("stalled result changed");

	// Input is refused only while a result waits on a stalled sink.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a waiting result");

	// An error result carries a code and no byte.
	a_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ERROR |-> error_code != ERR_NONE && !byte_valid
			&& !last_in_field && out_byte == 8'd0)
		else $error("malformed error result");

	// Content and done results carry no error code; done closes an integer.
	a_content: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_ERROR |-> error_code == ERR_NONE
			&& (kind != KIND_DONE || last_in_field))
		else $error("malformed content or done result");

endmodule

bind der_private_key_integer_parser_top dpkip_checker u_dpkip_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (blob.ready),
	.out_valid    (fields.valid),
	.out_ready    (fields.ready),
	.kind         (fields.kind),
	.field_index  (fields.field_index),
	.out_byte     (fields.out_byte),
	.byte_valid   (fields.byte_valid),
	.last_in_field(fields.last_in_field),
	.error_code   (fields.error_code)
);

FILE: dv/dpkip_tb_pkg.sv
// Scoreboard for the DER private key integer parser testbench.
// Predicts the result of every accepted blob byte and checks the results seen on the output.
// Depends on dpkip_pkg for the result type, tags, phases, kinds and error codes.
package dpkip_tb_pkg;
	import dpkip_pkg::*;

	class der_field_scoreboard;
		// Configuration as last written to the block.
		logic        key_kind;
		logic [7:0]  version_value;

		// Parser state, mirrored from the block's behavior.
		logic [2:0]  phase;
		logic [1:0]  header_role;
		logic [2:0]  len_bytes_left;
		logic [31:0] len_count;
		logic [7:0]  current_tag;
		logic [3:0]  field_count;

		dpkip_result_t expected_fields[$];
		int unsigned   results_checked;
		int unsigned   done_results;
		int unsigned   error_results;
		int unsigned   mismatches;

		function new();
			key_kind        = KEY_RSA;
			version_value   = 8'h00;
			phase           = PH_IDLE;
			header_role     = ROLE_SEQ;
			len_bytes_left  = 3'd0;
			len_count       = 32'd0;
			current_tag     = 8'h00;
			field_count     = 4'd0;
			results_checked = 0;
			done_results    = 0;
			error_results   = 0;
			mismatches      = 0;
		endfunction

		function void write_register(logic index, logic [7:0] data);
			if (index == CFG_KEY_KIND) begin
				key_kind = data[0];
			end else begin
				version_value = data;
			end
		endfunction

		function int unsigned pending();
			return expected_fields.size();
		endfunction

		function dpkip_result_t pack_result(logic [1:0] kind, logic [7:0] value, logic valid,
				logic last, logic [2:0] code);
			dpkip_result_t r;
			r.kind          = kind;
			r.field_index   = field_count[2:0];
			r.out_byte      = value;
			r.byte_valid    = valid;
			r.last_in_field = last;
			r.error_code    = code;
			return r;
		endfunction

		// An error ends the blob; bytes are ignored until the next first byte.
		function dpkip_result_t abort_blob(logic [2:0] code);
			phase = PH_IDLE;
			return pack_result(KIND_ERROR, 8'h00, 1'b0, 1'b0, code);
		endfunction

		// The final byte of an integer also signals done when it is the last integer.
		// The integer count is read here, so a key kind change mid-blob takes effect.
		function dpkip_result_t close_field(logic [7:0] value, logic valid);
			logic [4:0]    need;
			logic          done_now;
			dpkip_result_t r;
			need     = (key_kind == KEY_RSA) ? RSA_INT_COUNT : DSA_INT_COUNT;
			done_now = ({1'b0, field_count} + 5'd1 >= need);
			r = pack_result(done_now ? KIND_DONE : KIND_CONTENT, value, valid, 1'b1, ERR_NONE);
			if (done_now) begin
				phase = PH_IDLE;
			end else begin
				field_count = field_count + 4'd1;
				phase       = PH_TAG;
			end
			return r;
		endfunction

		// A complete length has been read for the header of the current role.
		function bit finish_header(output dpkip_result_t r);
			if (header_role == ROLE_SEQ) begin
				header_role = ROLE_VER;
				phase       = PH_TAG;
				return 1'b0;
			end
			if (header_role == ROLE_VER) begin
				if (len_count != 32'd1) begin
					r = abort_blob(ERR_VER_HEADER);
					return 1'b1;
				end
				phase = PH_VERSION;
				return 1'b0;
			end
			// A zero-length integer yields a marker result with no content byte.
			if (len_count == 32'd0) begin
				r = close_field(8'h00, 1'b0);
				return 1'b1;
			end
			phase = PH_CONTENT;
			return 1'b0;
		endfunction

		// Advances the parser by one byte; returns 1 when the byte causes a result.
		function bit parse_byte(logic first, logic [7:0] value, output dpkip_result_t r);
			logic [7:0] count_bytes;
			r = '0;
			if (first) begin
				phase          = PH_TAG;
				header_role    = ROLE_SEQ;
				len_bytes_left = 3'd0;
				len_count      = 32'd0;
				field_count    = 4'd0;
			end
			case (phase)
				PH_TAG: begin
					current_tag = value;
					if (header_role == ROLE_SEQ && value != TAG_SEQ) begin
						r = abort_blob(ERR_NO_SEQUENCE);
						return 1'b1;
					end
					if (header_role == ROLE_VER && value != TAG_INT) begin
						r = abort_blob(ERR_VER_HEADER);
						return 1'b1;
					end
					if (header_role == ROLE_INT && value != TAG_INT) begin
						r = abort_blob(ERR_NOT_INT);
						return 1'b1;
					end
					phase = PH_LEN_FIRST;
					return 1'b0;
				end
				PH_LEN_FIRST: begin
					if ((value & LONG_FORM_BIT) != 8'h00) begin
						count_bytes = value & ~LONG_FORM_BIT;
						if (count_bytes != 8'd1 && count_bytes != 8'd2 && count_bytes != 8'd4) begin
							r = abort_blob(ERR_LEN_FORM);
							return 1'b1;
						end
						len_bytes_left = count_bytes[2:0];
						len_count      = 32'd0;
						phase          = PH_LEN_MORE;
						return 1'b0;
					end
					len_count = {24'd0, value};
					return finish_header(r);
				end
				PH_LEN_MORE: begin
					// Big-endian length bytes; anything above 32 bits falls off the top.
					len_count      = {len_count[23:0], value};
					len_bytes_left = len_bytes_left - 3'd1;
					if (len_bytes_left == 3'd0) begin
						return finish_header(r);
					end
					return 1'b0;
				end
				PH_VERSION: begin
					if (value != version_value) begin
						r = abort_blob(ERR_BAD_VERSION);
						return 1'b1;
					end
					header_role = ROLE_INT;
					field_count = 4'd0;
					phase       = PH_TAG;
					return 1'b0;
				end
				PH_CONTENT: begin
					len_count = len_count - 32'd1;
					if (len_count == 32'd0) begin
						r = close_field(value, 1'b1);
						return 1'b1;
					end
					r = pack_result(KIND_CONTENT, value, 1'b1, 1'b0, ERR_NONE);
					return 1'b1;
				end
				default: begin
					phase = PH_IDLE;
					return 1'b0;
				end
			endcase
		endfunction

		// Called once per accepted input transaction.
		function void note_byte(logic first, logic [7:0] value);
			dpkip_result_t r;
			if (parse_byte(first, value, r)) begin
				expected_fields.push_back(r);
			end
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
			if (seen !== want) begin
				$error("%s: expected %0d, actual %0d", name, want, seen);
				mismatches++;
			end
		endfunction

		// Called once per accepted output transaction.
		function void check_result(dpkip_result_t seen);
			dpkip_result_t want;
			results_checked++;
			if (seen.kind == KIND_DONE) begin
				done_results++;
			end else if (seen.kind == KIND_ERROR) begin
				error_results++;
			end
			if (expected_fields.size() == 0) begin
				$error("unexpected result: kind %0d, field_index %0d, out_byte %0d, error_code %0d",
					seen.kind, seen.field_index, seen.out_byte, seen.error_code);
				mismatches++;
				return;
			end
			want = expected_fields.pop_front();
			compare_field("kind", 8'(want.kind), 8'(seen.kind));
			compare_field("field_index", 8'(want.field_index), 8'(seen.field_index));
			compare_field("out_byte", want.out_byte, seen.out_byte);
			compare_field("byte_valid", 8'(want.byte_valid), 8'(seen.byte_valid));
			compare_field("last_in_field", 8'(want.last_in_field), 8'(seen.last_in_field));
			compare_field("error_code", 8'(want.error_code), 8'(seen.error_code));
		endfunction
	endclass

endpackage

FILE: dv/testbench.sv
// Top-level testbench for der_private_key_integer_parser_top.
// Feeds directed and random DER key blobs under random flow control and checks every result.
// Depends on dpkip_pkg, dpkip_tb_pkg, the two channel interfaces and the block itself.
module testbench;
	import dpkip_pkg::*;
	import dpkip_tb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_BYTES = 1600;
	localparam logic        KEY_DSA      = ~KEY_RSA;

	typedef enum {RX_ALWAYS, RX_RANDOM, RX_CHOKED, RX_PERIODIC} rx_mode_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [7:0] cfg_data;

	dpkip_in_if  blob_if ();
	dpkip_out_if field_if ();

	der_field_scoreboard fields_sb = new();
	dpkip_result_t       observed;

	// Blob bytes waiting to be sent, each as {first_byte, in_byte}.
	logic [8:0]  byte_stream[$];
	logic        cfg_kind;
	logic [7:0]  cfg_version;
	int unsigned burst_left;
	int unsigned items_sent;
	int unsigned phase_count;
	rx_mode_t    rx_mode;
	int unsigned rx_left;

	der_private_key_integer_parser_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.blob     (blob_if),
		.fields   (field_if),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Output channel: ready follows one of four stall patterns, picked anew at random when each run ends.
	initial begin
		field_if.ready = 1'b0;
		rx_left = 0;
		rx_mode = RX_ALWAYS;
		forever begin
			@(posedge clk);
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(8, 64);
			end
			rx_left--;
			case (rx_mode)
				RX_ALWAYS:   field_if.ready <= 1'b1;
				RX_RANDOM:   field_if.ready <= 1'($urandom_range(0, 1));
				RX_CHOKED:   field_if.ready <= ($urandom_range(0, 5) == 0);
				default:     field_if.ready <= rx_left[2];
			endcase
		end
	end

	// Results are sampled mid-cycle, where every signal is settled.
	assign observed = {field_if.kind, field_if.field_index, field_if.out_byte,
		field_if.byte_valid, field_if.last_in_field, field_if.error_code};

	always @(negedge clk) begin
		if (arst_n && field_if.valid && field_if.ready) begin
			fields_sb.check_result(observed);
		end
	end

	initial begin
		#1_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic void push_byte(logic first, logic [7:0] value);
		byte_stream.push_back({first, value});
	endfunction

	// DER length in short form or in any long form wide enough for the value.
	function automatic void push_length(int unsigned n);
		int nb;
		int i;
		if (n < 128 && $urandom_range(0, 2) != 0) begin
			push_byte(1'b0, n[7:0]);
			return;
		end
		if (n < 256) begin
			case ($urandom_range(0, 2))
				0:       nb = 1;
				1:       nb = 2;
				default: nb = 4;
			endcase
		end else if (n < 65536) begin
			nb = ($urandom_range(0, 1) == 0) ? 2 : 4;
		end else begin
			nb = 4;
		end
		push_byte(1'b0, LONG_FORM_BIT | 8'(nb));
		for (i = nb - 1; i >= 0; i--) begin
			push_byte(1'b0, 8'(n >> (8 * i)));
		end
	endfunction

	// Mostly short integers, zero-length ones often, long ones now and then.
	function automatic int unsigned pick_int_length();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 30) return 0;
		if (pick < 75) return $urandom_range(1, 4);
		if (pick < 99) return $urandom_range(5, 20);
		return $urandom_range(128, 300);
	endfunction

	function automatic void push_key_blob(int ints, logic [7:0] version);
		int unsigned n;
		int          k;
		push_byte(1'b1, TAG_SEQ);
		push_length(($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 400));
		push_byte(1'b0, TAG_INT);
		push_length(1);
		push_byte(1'b0, version);
		for (k = 0; k < ints; k++) begin
			n = pick_int_length();
			push_byte(1'b0, TAG_INT);
			push_length(n);
			repeat (n) push_byte(1'b0, 8'($urandom_range(0, 255)));
		end
	endfunction

	// Appends one blob: mostly well formed, some damaged, some plain noise.
	function automatic void make_blob();
		int         pick;
		int         ints;
		int         start;
		int         cut;
		logic [7:0] version;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			repeat ($urandom_range(1, 6)) begin
				push_byte($urandom_range(0, 4) == 0, 8'($urandom_range(0, 255)));
			end
			return;
		end
		case ($urandom_range(0, 9))
			0:       ints = $urandom_range(0, 9);
			1:       ints = (cfg_kind == KEY_RSA) ? int'(DSA_INT_COUNT) : int'(RSA_INT_COUNT);
			default: ints = (cfg_kind == KEY_RSA) ? int'(RSA_INT_COUNT) : int'(DSA_INT_COUNT);
		endcase
		version = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : cfg_version;
		start = byte_stream.size();
		push_key_blob(ints, version);
		if (pick < 30) begin
			cut = $urandom_range(start + 1, byte_stream.size() - 1);
			case ($urandom_range(0, 2))
				0: byte_stream[cut][7:0] = 8'($urandom_range(0, 255));
				1: begin
					case ($urandom_range(0, 4))
						0:       byte_stream[cut][7:0] = LONG_FORM_BIT;
						1:       byte_stream[cut][7:0] = LONG_FORM_BIT | 8'($urandom_range(5, 127));
						2:       byte_stream[cut][7:0] = LONG_FORM_BIT | 8'd3;
						3:       byte_stream[cut][7:0] = TAG_SEQ;
						default: byte_stream[cut][7:0] = ~TAG_INT;
					endcase
				end
				default: begin
					while (byte_stream.size() > cut) void'(byte_stream.pop_back());
				end
			endcase
		end
	endfunction

	// Error paths and idle bytes, run at the reset configuration.
	function automatic void load_directed();
		push_byte(1'b0, 8'h00);
		push_byte(1'b1, 8'hFF);
		push_byte(1'b1, TAG_SEQ);
		push_byte(1'b0, LONG_FORM_BIT);
		push_byte(1'b1, TAG_SEQ);
		push_byte(1'b0, LONG_FORM_BIT | 8'd1);
		push_byte(1'b0, 8'h00);
		push_byte(1'b0, TAG_INT);
		push_byte(1'b0, 8'h00);
		push_byte(1'b1, TAG_SEQ);
		push_byte(1'b0, 8'h00);
		push_byte(1'b0, TAG_SEQ);
		push_byte(1'b1, TAG_SEQ);
		push_byte(1'b0, 8'h7F);
		push_byte(1'b0, TAG_INT);
		push_byte(1'b0, 8'h01);
		push_byte(1'b0, 8'hFF);
		push_byte(1'b1, TAG_SEQ);
		push_byte(1'b0, LONG_FORM_BIT | 8'd2);
		push_byte(1'b0, 8'hFF);
		push_byte(1'b0, 8'hFF);
		push_byte(1'b0, TAG_INT);
		push_byte(1'b0, 8'h01);
		push_byte(1'b0, 8'h00);
		push_byte(1'b0, 8'h03);
		push_byte(1'b0, TAG_INT);
	endfunction

	// Sends one input transaction; the sender pauses between bursts of random length.
	task automatic send_byte(input logic first, input logic [7:0] value);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 4);
			blob_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		blob_if.valid      <= 1'b1;
		blob_if.first_byte <= first;
		blob_if.in_byte    <= value;
		do @(negedge clk); while (blob_if.ready !== 1'b1);
		fields_sb.note_byte(first, value);
		@(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	task automatic write_register(input logic index, input logic [7:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		fields_sb.write_register(index, data);
		if (index == CFG_KEY_KIND) begin
			cfg_kind = data[0];
		end else begin
			cfg_version = data;
		end
	endtask

	// Stops sending and waits until every expected result has been taken.
	task automatic drain_results();
		blob_if.valid <= 1'b0;
		while (fields_sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Picks the settings for the next phase: the extremes first, then random ones.
	task automatic configure_phase();
		logic       new_kind;
		logic [7:0] new_version;
		logic       write_kind;
		logic       write_version;
		case (phase_count)
			0: begin new_kind = KEY_DSA; new_version = 8'hFF; end
			1: begin new_kind = KEY_RSA; new_version = 8'hFF; end
			2: begin new_kind = KEY_DSA; new_version = 8'h00; end
			3: begin new_kind = KEY_RSA; new_version = 8'h00; end
			default: begin
				new_kind = 1'($urandom_range(0, 1));
				case ($urandom_range(0, 4))
					0:       new_version = 8'h00;
					1:       new_version = 8'hFF;
					default: new_version = 8'($urandom_range(0, 255));
				endcase
			end
		endcase
		write_kind    = (phase_count < 4) || ($urandom_range(0, 9) < 7);
		write_version = (phase_count < 4) || ($urandom_range(0, 9) < 7);
		if (write_kind) write_register(CFG_KEY_KIND, {7'd0, new_kind});
		if (write_version) write_register(CFG_VERSION, new_version);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [8:0]  entry;
		int unsigned budget;
		arst_n             = 1'b0;
		blob_if.valid      = 1'b0;
		blob_if.first_byte = 1'b0;
		blob_if.in_byte    = 8'h00;
		cfg_we             = 1'b0;
		cfg_index          = CFG_KEY_KIND;
		cfg_data           = 8'h00;
		cfg_kind           = KEY_RSA;
		cfg_version        = 8'h00;
		burst_left         = 0;
		items_sent         = 0;
		phase_count        = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_directed();
		while (byte_stream.size() != 0) begin
			entry = byte_stream.pop_front();
			send_byte(entry[8], entry[7:0]);
		end
		drain_results();

		// A phase may end inside a blob, so the rest of it runs under new settings.
		while (items_sent < RANDOM_BYTES) begin
			configure_phase();
			budget = $urandom_range(60, 200);
			repeat (budget) begin
				if (byte_stream.size() == 0) make_blob();
				entry = byte_stream.pop_front();
				send_byte(entry[8], entry[7:0]);
			end
			drain_results();
			phase_count++;
		end
		repeat (10) @(posedge clk);

		if (fields_sb.pending() != 0) begin
			$error("%0d expected results never arrived", fields_sb.pending());
		end
		$display("Sent %0d blob bytes over %0d configuration phases; checked %0d results.",
			items_sent, phase_count, fields_sb.results_checked);
		$display("Blobs completed: %0d, blobs ended by an error: %0d.",
			fields_sb.done_results, fields_sb.error_results);
		if (fields_sb.mismatches == 0 && fields_sb.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
